// File: sv/rotenc_pkg.sv
// Shared types, constants and the half-step transition table for the rotary encoder decoder.
package rotenc_pkg;

  localparam int TRANSITIONS_PER_STEP_DEF = 2;

  typedef enum logic [2:0] {
    PH_START          = 3'd0,
    PH_CCW_BEGIN      = 3'd1,
    PH_CW_BEGIN       = 3'd2,
    PH_START_MID      = 3'd3,
    PH_CW_BEGIN_MID   = 3'd4,
    PH_CCW_BEGIN_MID  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    MARK_NONE = 2'd0,
    MARK_CW   = 2'd1,
    MARK_CCW  = 2'd2
  } mark_t;

  typedef struct packed {
    phase_t phase;
    mark_t  mark;
  } entry_t;

  typedef struct packed {
    logic step_taken;
    logic step_direction;
  } step_res_t;

  // code is {pin_a, pin_b}; unused phase codes behave as the start state
  function automatic entry_t next_entry(input phase_t phase, input logic [1:0] code);
    entry_t e;
    e.phase = PH_START;
    e.mark  = MARK_NONE;
    unique case (phase)
      PH_CCW_BEGIN: begin
        unique case (code)
          2'd0: begin e.phase = PH_START_MID; e.mark = MARK_CCW; end
          2'd1: e.phase = PH_START;
          2'd2: e.phase = PH_CCW_BEGIN;
          default: e.phase = PH_START;
        endcase
      end
      PH_CW_BEGIN: begin
        unique case (code)
          2'd0: begin e.phase = PH_START_MID; e.mark = MARK_CW; end
          2'd1: e.phase = PH_CW_BEGIN;
          2'd2: e.phase = PH_START;
          default: e.phase = PH_START;
        endcase
      end
      PH_START_MID: begin
        unique case (code)
          2'd0: e.phase = PH_START_MID;
          2'd1: e.phase = PH_CCW_BEGIN_MID;
          2'd2: e.phase = PH_CW_BEGIN_MID;
          default: e.phase = PH_START;
        endcase
      end
      PH_CW_BEGIN_MID: begin
        unique case (code)
          2'd0: e.phase = PH_START_MID;
          2'd1: e.phase = PH_START_MID;
          2'd2: e.phase = PH_CW_BEGIN_MID;
          default: begin e.phase = PH_START; e.mark = MARK_CW; end
        endcase
      end
      PH_CCW_BEGIN_MID: begin
        unique case (code)
          2'd0: e.phase = PH_START_MID;
          2'd1: e.phase = PH_CCW_BEGIN_MID;
          2'd2: e.phase = PH_START_MID;
          default: begin e.phase = PH_START; e.mark = MARK_CCW; end
        endcase
      end
      default: begin
        unique case (code)
          2'd0: e.phase = PH_START_MID;
          2'd1: e.phase = PH_CW_BEGIN;
          2'd2: e.phase = PH_CCW_BEGIN;
          default: e.phase = PH_START;
        endcase
      end
    endcase
    return e;
  endfunction

endpackage

// File: sv/rotenc_ifs.sv
// Handshake channel interfaces for pin samples, step results and the enable register.
interface rotenc_sample_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  modport source (output valid, output pin_a, output pin_b, input ready);
  modport sink (input valid, input pin_a, input pin_b, output ready);
endinterface

interface rotenc_step_if;
  logic valid;
  logic ready;
  logic step_taken;
  logic step_direction;
  modport source (output valid, output step_taken, output step_direction, input ready);
  modport sink (input valid, input step_taken, input step_direction, output ready);
endinterface

interface rotenc_cfg_if;
  logic valid;
  logic ready;
  logic event_enable;
  modport source (output valid, output event_enable, input ready);
  modport sink (input valid, input event_enable, output ready);
endinterface

// File: sv/rotenc_step.sv
// Next-state logic: table lookup, transition counter update and step decision.
module rotenc_step #(
  parameter int TRANSITIONS_PER_STEP = rotenc_pkg::TRANSITIONS_PER_STEP_DEF,
  parameter int CNT_W = 1
) (
  input  rotenc_pkg::phase_t    phase,
  input  logic [CNT_W-1:0]      count,
  input  logic                  enable,
  input  logic                  pin_a,
  input  logic                  pin_b,
  output rotenc_pkg::phase_t    phase_next,
  output logic [CNT_W-1:0]      count_next,
  output rotenc_pkg::step_res_t res
);

  rotenc_pkg::entry_t entry;
  logic               marked;
  logic [CNT_W:0]     count_inc;
  logic               hit;

  always_comb begin
    entry      = rotenc_pkg::next_entry(phase, {pin_a, pin_b});
    phase_next = entry.phase;
    marked     = enable && (entry.mark == rotenc_pkg::MARK_CW ||
                            entry.mark == rotenc_pkg::MARK_CCW);
    count_inc  = {1'b0, count} + (CNT_W+1)'(1);
    hit        = count_inc >= (CNT_W+1)'(TRANSITIONS_PER_STEP);
    count_next = count;
    res.step_taken     = 1'b0;
    res.step_direction = 1'b0;
    if (marked) begin
      if (hit) begin
        count_next         = '0;
        res.step_taken     = 1'b1;
        res.step_direction = (entry.mark == rotenc_pkg::MARK_CCW);
      end else begin
        count_next = count_inc[CNT_W-1:0];
      end
    end
  end

endmodule

// File: sv/rotary_encoder_step_decoder.sv
// Rotary encoder half-step decoder: one pin sample in, one step result out per beat.
// Takes one sample every clock cycle when the result side keeps up; each sample passes
// through the input register, then the result register, before its result appears. The
// phase and counter registers are updated in the same cycle the sample moves into the
// result register, so that feedback loop sets the rate. event_enable resets to 1
// and is written through the cfg channel, which is always ready.
module rotary_encoder_step_decoder #(
  parameter int TRANSITIONS_PER_STEP = rotenc_pkg::TRANSITIONS_PER_STEP_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  rotenc_cfg_if.sink              cfg,
  rotenc_sample_if.sink           samples,
  rotenc_step_if.source           steps
);

  localparam int CNT_W = (TRANSITIONS_PER_STEP > 1) ? $clog2(TRANSITIONS_PER_STEP) : 1;

  logic                  event_enable;
  logic                  s1_valid;
  logic                  s1_pin_a;
  logic                  s1_pin_b;
  logic                  s1_adv;
  logic                  out_valid;
  rotenc_pkg::step_res_t out_res;
  rotenc_pkg::phase_t    phase;
  rotenc_pkg::phase_t    phase_next;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  rotenc_pkg::step_res_t res_next;

  assign cfg.ready     = 1'b1;
  assign s1_adv        = s1_valid && (!out_valid || steps.ready);
  assign samples.ready = !s1_valid || s1_adv;

  assign steps.valid          = out_valid;
  assign steps.step_taken     = out_res.step_taken;
  assign steps.step_direction = out_res.step_direction;

  rotenc_step #(
    .TRANSITIONS_PER_STEP(TRANSITIONS_PER_STEP),
    .CNT_W(CNT_W)
  ) u_step (
    .phase(phase),
    .count(count),
    .enable(event_enable),
    .pin_a(s1_pin_a),
    .pin_b(s1_pin_b),
    .phase_next(phase_next),
    .count_next(count_next),
    .res(res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      event_enable <= 1'b1;
    end else if (cfg.valid) begin
      event_enable <= cfg.event_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      phase     <= rotenc_pkg::PH_START;
      count     <= '0;
    end else begin
      if (samples.ready) begin
        s1_valid <= samples.valid;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
        phase     <= phase_next;
        count     <= count_next;
      end else if (steps.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_pin_a <= samples.pin_a;
      s1_pin_b <= samples.pin_b;
    end
    if (s1_adv) begin
      out_res <= res_next;
    end
  end

`ifndef SYNTH
  a_dir_only_with_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.step_direction |-> out_res.step_taken)
    else $error("step direction set without a step");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, count} < (CNT_W+1)'(TRANSITIONS_PER_STEP))
    else $error("transition counter out of range");

  a_step_clears_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.step_taken |-> count == '0)
    else $error("counter not cleared after a step");

  a_disabled_holds_count: assert property (@(posedge clk) disable iff (rst)
    !event_enable && !cfg.valid |=> $stable(count))
    else $error("counter moved while disabled");

  a_stalled_sample_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_pin_a) && $stable(s1_pin_b))
    else $error("held sample lost or changed");
`endif

endmodule
